### sv/set_assoc_lru_cache_model_defines.svh
// Assertion macros for the checker file of the cache model.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define SALC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion that is checked in reset as well.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/salc_pkg.sv
`default_nettype none

package salc_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int ADDR_W     = 64;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int TOTAL_W    = 32;
    localparam int OUT_DATA_W = 104;
    // Way and age fields in the scan result, wide enough for sixteen ways.
    localparam int WAY_ID_W   = 4;

    // Access kinds carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSV    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    // Outcome of one pass of the way scanner over a set.
    typedef struct packed {
        logic                done;
        logic                hit;
        logic [WAY_ID_W-1:0] hit_way;
        logic                inv_found;
        logic [WAY_ID_W-1:0] inv_way;
        logic [WAY_ID_W-1:0] old_way;
        logic [WAY_ID_W-1:0] old_age;
    } t_scan_res;

endpackage

`default_nettype wire

### sv/set_assoc_lru_cache_model.sv
// Channel  | Direction | Word contents (lowest bit first)                      | Handshake
// s_axis   | in        | tdata: address[63:0]; tuser: func[1:0]                | tvalid/tready
// m_axis   | out       | tdata: hit, evicted, hits_total, misses_total,        | tvalid/tready
//          |           |        evictions_total, 6 zero bits; tlast: last      |
// cfg      | in        | i_cfg_addr selects set_bits, block_bits or ways       | i_cfg_we
//
// A load or store runs through the address split, the row read, one tag compare per
// way in use through a single comparator, a registered hand-over of the scan result,
// and the row write-back; the input is free again once that write-back is done.
// A modify repeats all but the split and frees the input after its second write-back.
// A held result stalls only the write-back of the next access.
// Reset is synchronous and active low; it clears all line valid bits at once.

`default_nettype none

module set_assoc_lru_cache_model import salc_pkg::*; #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 4,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [ADDR_W-1:0]     i_s_axis_tdata,   // address[63:0]
    input  wire logic [FUNC_W-1:0]     i_s_axis_tuser,   // func[1:0]
    // Result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // hit, evicted, hits_total,
                                                         // misses_total, evictions_total, pad
    output logic                       o_m_axis_tlast,
    // Configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_FLOOR = $clog2(MAX_SETS + 1) - 1;
    localparam int SB_MAX   = (SB_FLOOR > 30) ? 30 : SB_FLOOR;
    localparam int SB_CAP   = (SB_MAX > 7) ? 7 : SB_MAX;
    localparam int AW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WIW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW      = $clog2(MAX_WAYS + 1);
    localparam int RPT_W    = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
    localparam int PAD_W    = OUT_DATA_W - (2 + 3 * TOTAL_W);
    localparam logic [AW-1:0]         AGE_TOP = AW'(MAX_WAYS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_READ,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state                            r_state;
    logic [2:0]                        r_set_bits;
    logic [5:0]                        r_block_bits;
    logic [2:0]                        r_ways;
    logic [ADDR_W-1:0]                 r_addr;
    logic                              r_more;
    logic [SW-1:0]                     r_set;
    logic [ADDR_W-1:0]                 r_tag;
    logic [MAX_WAYS-1:0]               r_valid [MAX_SETS];
    logic [MAX_WAYS-1:0]               r_vrow;
    logic [COUNT_BITS-1:0]             r_hit_cnt;
    logic [COUNT_BITS-1:0]             r_miss_cnt;
    logic [COUNT_BITS-1:0]             r_evict_cnt;
    logic                              r_out_valid;
    logic [OUT_DATA_W-1:0]             r_out_data;
    logic                              r_out_last;

    logic [2:0]                        eff_sb;
    logic [WCW-1:0]                    nw;
    logic [SW-1:0]                     set_mask;
    logic [ADDR_W-1:0]                 blk;
    logic [6:0]                        tag_shift;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]   rd_tags;
    logic [MAX_WAYS-1:0][AW-1:0]       rd_ages;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]   n_tags;
    logic [MAX_WAYS-1:0][AW-1:0]       n_ages;
    t_scan_res                         scan_res;
    logic [WIW-1:0]                    w;
    logic [AW:0]                       limit;
    logic                              evict;
    logic                              can_load;
    logic                              do_write;
    logic [COUNT_BITS-1:0]             n_hit_cnt;
    logic [COUNT_BITS-1:0]             n_miss_cnt;
    logic [COUNT_BITS-1:0]             n_evict_cnt;
    logic [OUT_DATA_W-1:0]             n_out_data;

    // Clamp a running count to the 32-bit reported total.
    function automatic logic [TOTAL_W-1:0] report_total(input logic [COUNT_BITS-1:0] c);
        logic [RPT_W-1:0] e;
        e = RPT_W'(c);
        if ((e >> TOTAL_W) != '0) begin
            return '1;
        end
        return e[TOTAL_W-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd0;
            r_block_bits <= 6'd0;
            r_ways       <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                REG_WAYS:       r_ways       <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Effective geometry from the registers.
    always_comb begin
        eff_sb = (r_set_bits > 3'(SB_CAP)) ? 3'(SB_CAP) : r_set_bits;
        if (r_ways == 3'd0) begin
            nw = WCW'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            nw = WCW'(MAX_WAYS);
        end else begin
            nw = WCW'(r_ways);
        end
        set_mask  = ~({SW{1'b1}} << eff_sb);
        blk       = r_addr >> r_block_bits;
        tag_shift = {1'b0, r_block_bits} + 7'(eff_sb);
    end

    salc_row_mem #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ),
        .i_wr_en   (do_write),
        .i_addr    (r_set),
        .i_wr_tags (n_tags),
        .i_wr_ages (n_ages),
        .o_rd_tags (rd_tags),
        .o_rd_ages (rd_ages)
    );

    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_READ),
        .i_nw        (nw),
        .i_tag       (r_tag),
        .i_row_tags  (rd_tags),
        .i_row_ages  (rd_ages),
        .i_row_valid (r_vrow),
        .o_res       (scan_res)
    );

    // Pick the way to touch and the age bound for aging the others.
    always_comb begin
        evict = 1'b0;
        if (scan_res.hit) begin
            w     = WIW'(scan_res.hit_way);
            limit = {1'b0, rd_ages[w]};
        end else if (scan_res.inv_found) begin
            w     = WIW'(scan_res.inv_way);
            limit = (AW+1)'(MAX_WAYS);
        end else begin
            w     = WIW'(scan_res.old_way);
            limit = {1'b0, AW'(scan_res.old_age)};
            evict = 1'b1;
        end

        // New row: touched way goes youngest, younger valid ways age by one.
        n_tags = rd_tags;
        n_ages = rd_ages;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (j < int'(nw)) begin
                if (WIW'(j) == w) begin
                    n_ages[j] = '0;
                end else if (r_vrow[j] && ({1'b0, rd_ages[j]} < limit)
                             && (rd_ages[j] < AGE_TOP)) begin
                    n_ages[j] = rd_ages[j] + AW'(1);
                end
            end
        end
        if (!scan_res.hit) begin
            n_tags[w] = r_tag;
        end
    end

    // Saturating counters and the result word.
    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_evict_cnt = r_evict_cnt;
        if (scan_res.hit) begin
            if (r_hit_cnt != CNT_MAX) begin
                n_hit_cnt = r_hit_cnt + COUNT_BITS'(1);
            end
        end else begin
            if (r_miss_cnt != CNT_MAX) begin
                n_miss_cnt = r_miss_cnt + COUNT_BITS'(1);
            end
            if (evict && (r_evict_cnt != CNT_MAX)) begin
                n_evict_cnt = r_evict_cnt + COUNT_BITS'(1);
            end
        end
        n_out_data = {{PAD_W{1'b0}}, report_total(n_evict_cnt), report_total(n_miss_cnt),
                      report_total(n_hit_cnt), evict, scan_res.hit};
    end

    assign can_load = !r_out_valid || i_m_axis_tready;
    assign do_write = (r_state == S_UPDATE) && can_load;

    // Sequencer, line valid bits, counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_more      <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < MAX_SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_axis_tready && !do_write) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_addr <= i_s_axis_tdata;
                        unique case (i_s_axis_tuser) inside
                            FUNC_LOAD, FUNC_STORE: begin
                                r_more  <= 1'b0;
                                r_state <= S_SPLIT;
                            end
                            FUNC_MODIFY: begin
                                r_more  <= 1'b1;
                                r_state <= S_SPLIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SPLIT: begin
                    r_set   <= blk[SW-1:0] & set_mask;
                    r_tag   <= r_addr >> tag_shift;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_vrow  <= r_valid[r_set];
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_res.done) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (can_load) begin
                        r_valid[r_set][w] <= 1'b1;
                        r_hit_cnt         <= n_hit_cnt;
                        r_miss_cnt        <= n_miss_cnt;
                        r_evict_cnt       <= n_evict_cnt;
                        r_out_valid       <= 1'b1;
                        r_out_data        <= n_out_data;
                        r_out_last        <= !r_more;
                        if (r_more) begin
                            r_more  <= 1'b0;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### sv/salc_row_mem.sv
`default_nettype none

module salc_row_mem import salc_pkg::*; #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 4
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rd_en,
    input  wire logic                                        i_wr_en,
    input  wire logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] i_addr,
    input  wire logic [MAX_WAYS-1:0][ADDR_W-1:0]             i_wr_tags,
    input  wire logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] i_wr_ages,
    output logic      [MAX_WAYS-1:0][ADDR_W-1:0]             o_rd_tags,
    output logic      [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] o_rd_ages
);

    localparam int AW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAGS_W = MAX_WAYS * ADDR_W;
    localparam int AGES_W = MAX_WAYS * AW;
    localparam int ROW_W  = TAGS_W + AGES_W;

    // One row holds all tags and ages of a set.
    logic [ROW_W-1:0] r_mem [MAX_SETS];
    logic [ROW_W-1:0] r_rd;

    // Single port: a write and a registered read at the same row address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_wr_ages, i_wr_tags};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rd_tags = r_rd[TAGS_W-1:0];
    assign o_rd_ages = r_rd[ROW_W-1:TAGS_W];

endmodule

`default_nettype wire

### sv/salc_way_scan.sv
`default_nettype none

module salc_way_scan import salc_pkg::*; #(
    parameter int MAX_WAYS = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [$clog2(MAX_WAYS+1)-1:0]        i_nw,
    input  wire logic [ADDR_W-1:0]                    i_tag,
    input  wire logic [MAX_WAYS-1:0][ADDR_W-1:0]      i_row_tags,
    input  wire logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] i_row_ages,
    input  wire logic [MAX_WAYS-1:0]                  i_row_valid,
    output t_scan_res                                 o_res
);

    localparam int AW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW = $clog2(MAX_WAYS + 1);

    logic           r_busy;
    logic           r_done;
    logic [WIW-1:0] r_way;
    logic           r_hit;
    logic [WIW-1:0] r_hit_way;
    logic           r_inv_found;
    logic [WIW-1:0] r_inv_way;
    logic [WIW-1:0] r_old_way;
    logic [AW-1:0]  r_old_age;

    logic           way_match;
    logic           way_last;
    logic [AW-1:0]  way_age;

    // The one tag comparator, applied to the way under the scan pointer.
    assign way_match = i_row_valid[r_way] && (i_row_tags[r_way] == i_tag);
    assign way_age   = i_row_ages[r_way];
    assign way_last  = (WCW'(r_way) == (i_nw - WCW'(1)));

    // Walk the ways in use one per cycle, keeping first hit, first free and oldest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && way_last;
            if (i_start) begin
                r_busy      <= 1'b1;
                r_way       <= '0;
                r_hit       <= 1'b0;
                r_inv_found <= 1'b0;
            end else if (r_busy) begin
                if (!r_hit && way_match) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= r_way;
                end
                if (!r_inv_found && !i_row_valid[r_way]) begin
                    r_inv_found <= 1'b1;
                    r_inv_way   <= r_way;
                end
                if ((r_way == '0) || (way_age > r_old_age)) begin
                    r_old_way <= r_way;
                    r_old_age <= way_age;
                end
                if (way_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_way <= r_way + WIW'(1);
                end
            end
        end
    end

    always_comb begin
        o_res.done      = r_done;
        o_res.hit       = r_hit;
        o_res.hit_way   = WAY_ID_W'(r_hit_way);
        o_res.inv_found = r_inv_found;
        o_res.inv_way   = WAY_ID_W'(r_inv_way);
        o_res.old_way   = WAY_ID_W'(r_old_way);
        o_res.old_age   = WAY_ID_W'(r_old_age);
    end

endmodule

`default_nettype wire

### sv/salc_checker.sv
`default_nettype none

`include "set_assoc_lru_cache_model_defines.svh"

module salc_checker import salc_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [FUNC_W-1:0]     i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A result word stays offered until it is taken.
    `SALC_ASSERT(a_out_hold,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid,
        "result word dropped while stalled")

    // Reset empties the result register.
    `SALC_ASSERT_ALWAYS(a_rst_empty,
        !i_rst_n |=> !o_m_axis_tvalid,
        "result word valid after reset")

    // A taken access keeps the input closed while the set is worked on.
    `SALC_ASSERT(a_busy_after_take,
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != FUNC_RSV) |=> !o_s_axis_tready,
        "input open right after an access was taken")

    // A hit never replaces a line.
    `SALC_ASSERT(a_hit_no_evict,
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]),
        "result reports a hit and an eviction")

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (.*);

`default_nettype wire

### test/tb_set_assoc_lru_cache_model.sv
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model;
    import salc_pkg::*;

    localparam int SETS_MAX       = 64;
    localparam int WAYS_MAX       = 4;
    localparam int SET_BITS_MAX   = $clog2(SETS_MAX);
    localparam int QUIET_CYCLES   = 32;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int ITEMS_PER_RUN  = 166;
    localparam int REPORT_LIMIT   = 10;

    // Outcome of one cache access as it appears on the result stream.
    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        logic        last;
    } t_access_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [ADDR_W-1:0]     i_s_axis_tdata;   // address[63:0]
    logic [FUNC_W-1:0]     i_s_axis_tuser;   // func[1:0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // hit, evicted, hits_total, misses_total,
                                             // evictions_total, pad
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the cache contents and counters.
    logic        line_ok [SETS_MAX*WAYS_MAX];
    logic [63:0] line_key [SETS_MAX*WAYS_MAX];
    int          line_rank [SETS_MAX*WAYS_MAX];
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;
    logic [31:0] evict_cnt;
    int          cfg_set_bits;
    int          cfg_block_bits;
    int          cfg_ways;

    t_access_outcome pending_outcomes [$];
    t_access_outcome want;
    t_access_outcome got;
    int              err_cnt = 0;
    int              cycle_cnt = 0;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;

    set_assoc_lru_cache_model u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_set_assoc_lru_cache_model: errors");
            $finish;
        end
    end

    // The receiver stalls at random with the current stall rate.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Make way w of the set most recent; valid ways younger than limit age by one.
    function automatic void promote_way(input int base, input int nw, input int w,
                                        input int limit);
        int k;
        for (int j = 0; j < nw; j++) begin
            k = base + j;
            if (j != w && line_ok[k] && line_rank[k] < limit && line_rank[k] < WAYS_MAX - 1)
                line_rank[k]++;
        end
        line_rank[base + w] = 0;
    endfunction

    // One lookup in the shadow cache; updates the state and returns the outcome.
    function automatic t_access_outcome predict_access(input logic [63:0] addr,
                                                       input logic is_last);
        int              sb;
        int              nw;
        int              base;
        int              victim;
        int              oldest;
        logic [63:0]     blk;
        logic [63:0]     tag;
        t_access_outcome res;
        res    = '0;
        sb     = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
        nw     = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways;
        blk    = addr >> cfg_block_bits;
        tag    = blk >> sb;
        base   = int'(blk & ((64'd1 << sb) - 64'd1)) * WAYS_MAX;
        victim = -1;
        for (int j = 0; j < nw; j++) begin
            if (line_ok[base + j] && line_key[base + j] == tag) begin
                promote_way(base, nw, j, line_rank[base + j]);
                res.hit = 1'b1;
                break;
            end
        end
        if (res.hit) begin
            if (hit_cnt != '1) hit_cnt++;
        end else begin
            for (int j = 0; j < nw; j++) begin
                if (!line_ok[base + j]) begin
                    victim = j;
                    break;
                end
            end
            if (victim < 0) begin
                // Set is full: replace the least recent way.
                victim = 0;
                oldest = line_rank[base];
                for (int j = 1; j < nw; j++) begin
                    if (line_rank[base + j] > oldest) begin
                        oldest = line_rank[base + j];
                        victim = j;
                    end
                end
                res.evicted = 1'b1;
                if (evict_cnt != '1) evict_cnt++;
                promote_way(base, nw, victim, oldest);
            end else begin
                promote_way(base, nw, victim, WAYS_MAX);
            end
            line_ok[base + victim]  = 1'b1;
            line_key[base + victim] = tag;
            if (miss_cnt != '1) miss_cnt++;
        end
        res.hits      = hit_cnt;
        res.misses    = miss_cnt;
        res.evictions = evict_cnt;
        res.last      = is_last;
        return res;
    endfunction

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.hit       = o_m_axis_tdata[0];
            got.evicted   = o_m_axis_tdata[1];
            got.hits      = o_m_axis_tdata[33:2];
            got.misses    = o_m_axis_tdata[65:34];
            got.evictions = o_m_axis_tdata[97:66];
            got.last      = o_m_axis_tlast;
            if (pending_outcomes.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_LIMIT)
                    $display("%0t: result word with nothing expected", $realtime);
            end else begin
                want = pending_outcomes.pop_front();
                if (got != want) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT) begin
                        $display("%0t: expected hit=%0b ev=%0b hits=%0d miss=%0d evict=%0d last=%0b",
                                 $realtime, want.hit, want.evicted, want.hits,
                                 want.misses, want.evictions, want.last);
                        $display("%0t: got      hit=%0b ev=%0b hits=%0d miss=%0d evict=%0d last=%0b",
                                 $realtime, got.hit, got.evicted, got.hits,
                                 got.misses, got.evictions, got.last);
                    end
                end
            end
        end
    end

    // Send one access word; called and returning at a falling edge.
    task automatic send_access(input logic [FUNC_W-1:0] func, input logic [63:0] addr);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (func == FUNC_LOAD || func == FUNC_STORE) begin
            pending_outcomes.push_back(predict_access(addr, 1'b1));
        end else if (func == FUNC_MODIFY) begin
            pending_outcomes.push_back(predict_access(addr, 1'b0));
            pending_outcomes.push_back(predict_access(addr, 1'b1));
        end
        @(negedge i_clk);
    endtask

    // Hold the input until every expected word has arrived.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    // Drain and let an ignored item that may still be in flight finish.
    task automatic settle_block();
        wait_for_results();
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers back to back; only while the block is idle.
    task automatic apply_config(input int sb, input int bb, input int nw);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_SET_BITS;
        i_cfg_data <= CFG_DATA_W'(sb);
        @(negedge i_clk);
        i_cfg_addr <= REG_BLOCK_BITS;
        i_cfg_data <= CFG_DATA_W'(bb);
        @(negedge i_clk);
        i_cfg_addr <= REG_WAYS;
        i_cfg_data <= CFG_DATA_W'(nw);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_set_bits   = sb & 7;
        cfg_block_bits = bb & 63;
        cfg_ways       = nw & 7;
    endtask

    // Address drawn mostly from a small pool of blocks so that lines get reused.
    function automatic logic [63:0] pick_address();
        int          sb;
        int          nw;
        logic [63:0] blk;
        logic [63:0] noise;
        sb    = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
        nw    = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways;
        noise = {$urandom, $urandom};
        if ($urandom_range(19) == 0)
            return noise;
        blk = 64'($urandom_range(0, (1 << sb) * nw * 2 + 1));
        return (blk << cfg_block_bits) | (noise & ((64'd1 << cfg_block_bits) - 64'd1));
    endfunction

    // Register values after reset, with the smallest and largest addresses.
    task automatic test_reset_defaults();
        src_idle_pct   = 23;
        sink_stall_pct = 23;
        send_access(FUNC_LOAD, 64'd0);
        send_access(FUNC_STORE, 64'd0);
        send_access(FUNC_MODIFY, '1);
        send_access(FUNC_RSV, {$urandom, $urandom});
        send_access(FUNC_LOAD, 64'd0);
        settle_block();
    endtask

    // Too many set bits, the widest block offset and a ways count of zero.
    task automatic test_split_extremes();
        apply_config(7, 63, 0);
        send_access(FUNC_LOAD, 64'd0);
        send_access(FUNC_LOAD, 64'h8000_0000_0000_0000);
        send_access(FUNC_MODIFY, 64'h7fff_ffff_ffff_ffff);
        send_access(FUNC_STORE, '1);
        send_access(FUNC_RSV, 64'd0);
        settle_block();
    endtask

    // Fill one set past its ways and check the least recent line goes first.
    task automatic test_lru_order();
        apply_config(2, 4, 7);
        for (int t = 1; t <= 4; t++)
            send_access(FUNC_LOAD, 64'(t) << 6);
        send_access(FUNC_LOAD, 64'd1 << 6);
        send_access(FUNC_LOAD, 64'd5 << 6);
        send_access(FUNC_STORE, 64'd2 << 6);
        send_access(FUNC_MODIFY, 64'd3 << 6);
        send_access(FUNC_LOAD, (64'd1 << 6) | 64'h3f);
        send_access(FUNC_STORE, (64'd1 << 6) | (64'd3 << 4) | 64'hf);
        settle_block();
    endtask

    // Random accesses over several register settings and idle patterns.
    task automatic test_random_phases();
        int          sb_list [8]   = '{1, 3, 6, 2, 0, 7, 4, 2};
        int          bb_list [8]   = '{2, 5, 0, 32, 63, 6, 1, 3};
        int          ways_list [8] = '{2, 4, 3, 5, 1, 4, 0, 4};
        int          src_list [8]  = '{0, 57, 0, 23, 0, 57, 0, 23};
        int          sink_list [8] = '{0, 0, 57, 23, 0, 0, 57, 23};
        int          n;
        logic [1:0]  func;
        for (int p = 0; p < 8; p++) begin
            src_idle_pct   = src_list[p];
            sink_stall_pct = sink_list[p];
            apply_config(sb_list[p], bb_list[p], ways_list[p]);
            n = 0;
            while (n < ITEMS_PER_RUN) begin
                if ($urandom_range(99) < 4) begin
                    send_access(FUNC_RSV, {$urandom, $urandom});
                end else begin
                    func = 2'($urandom_range(2));
                    send_access(func, pick_address());
                    n++;
                end
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
            settle_block();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = FUNC_LOAD;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_SET_BITS;
        i_cfg_data      = '0;
        for (int k = 0; k < SETS_MAX * WAYS_MAX; k++) begin
            line_ok[k]   = 1'b0;
            line_key[k]  = '0;
            line_rank[k] = 0;
        end
        hit_cnt        = '0;
        miss_cnt       = '0;
        evict_cnt      = '0;
        cfg_set_bits   = 0;
        cfg_block_bits = 0;
        cfg_ways       = 1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_split_extremes();
        test_lru_order();
        test_random_phases();

        settle_block();
        if (err_cnt == 0)
            $display("tb_set_assoc_lru_cache_model: clean");
        else
            $display("tb_set_assoc_lru_cache_model: errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/salc_pkg.sv
sv/salc_row_mem.sv
sv/salc_way_scan.sv
sv/set_assoc_lru_cache_model.sv
sv/salc_checker.sv
test/tb_set_assoc_lru_cache_model.sv
